FILE: rtl/core/nbtr_pkg.sv
// Package for the nested busy-time ratio meter.
// Holds the operation codes, field widths and the ratio scale.
// No dependencies.
package nbtr_pkg;

    localparam int TS_BITS       = 48;
    localparam int INTERVAL_BITS = 32;
    localparam int RATIO_BITS    = 14;

    typedef logic [1:0] t_op;

    localparam t_op OP_ENTER = 2'd0;
    localparam t_op OP_LEAVE = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;
    localparam t_op OP_QUERY = 2'd3;

    localparam logic [RATIO_BITS-1:0] RATIO_SCALE = 14'd10000;

endpackage

FILE: rtl/core/nbtr_if.sv
// Valid/ready channel interfaces for the nested busy-time ratio meter.
// Depends on nbtr_pkg for the field widths and the operation type.
interface nbtr_evt_if;
    logic                             valid;
    logic                             ready;
    nbtr_pkg::t_op                    operation;
    logic [nbtr_pkg::TS_BITS-1:0]     timestamp;

    modport source (output valid, output operation, output timestamp, input ready);
    modport sink   (input valid, input operation, input timestamp, output ready);
endinterface

interface nbtr_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [nbtr_pkg::INTERVAL_BITS-1:0]   interval;
    logic [nbtr_pkg::RATIO_BITS-1:0]      ratio;
    logic                                 error;

    modport source (output valid, output interval, output ratio, output error, input ready);
    modport sink   (input valid, input interval, input ratio, input error, output ready);
endinterface

FILE: rtl/core/nested_busy_time_ratio_meter.sv
// Nested busy-time ratio meter: measures nested busy intervals and reports the busy share.
// Depends on nbtr_pkg and on the channel interfaces in nbtr_if.sv.
//
// Usage:
//   i_evt carries one event per transfer (operation, timestamp); o_res returns
//   exactly one result per event (interval, ratio, error), in order.
//   The interval, total and ratio arithmetic runs through one shared adder/subtractor under a sequencer,
//   and i_evt.ready is high only while the sequencer is idle.
//   Sequencer steps per event: clear, queries with both totals zero and events
//   that close no interval go straight to the output step; an enter or leave
//   that closes an interval takes a difference, then a saturating add; a query
//   takes one add for the divisor, 14 shift-add steps for the scaled numerator
//   and 14 restoring division steps.
//   The result sits in an output register, so the next event is taken while
//   a result still waits. If the receiver stalls, the finished result of the
//   following event is held inside until the output register is free.
//   Reset (synchronous, active low) clears the mark, the totals, the depth
//   and the output valid flag.
module nested_busy_time_ratio_meter #(
    parameter int TIME_BITS  = 48,
    parameter int DEPTH_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nbtr_evt_if.sink          i_evt,
    nbtr_res_if.source        o_res
);
    import nbtr_pkg::*;

    localparam int W = TIME_BITS + RATIO_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_ACCUM = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                 r_state, n_state;
    logic [TIME_BITS-1:0]       r_mark, r_in_tot, r_out_tot, r_now;
    logic [DEPTH_BITS-1:0]      r_depth;
    logic                       r_enter;
    logic [W-1:0]               r_acc;
    logic [TIME_BITS:0]         r_dvs;
    logic [3:0]                 r_cnt;
    logic [RATIO_BITS-1:0]      r_quo;
    logic [INTERVAL_BITS-1:0]   r_interval;
    logic [RATIO_BITS-1:0]      r_ratio;
    logic                       r_err;
    logic                       r_ov;
    logic [INTERVAL_BITS-1:0]   r_o_interval;
    logic [RATIO_BITS-1:0]      r_o_ratio;
    logic                       r_o_err;

    logic [TS_BITS+TIME_BITS-1:0] ts_ext;
    logic [TIME_BITS-1:0]       now;
    logic [W-1:0]               add_a, add_b;
    logic                       add_sub;
    logic [W:0]                 add_sum;
    logic [TIME_BITS-1:0]       sat_val;
    logic                       accept, load_out;

    assign ts_ext = {{TIME_BITS{1'b0}}, i_evt.timestamp};
    assign now    = ts_ext[TIME_BITS-1:0];

    assign i_evt.ready = (r_state == S_IDLE);
    assign accept      = i_evt.valid && (r_state == S_IDLE);
    assign load_out    = (r_state == S_OUT) && (!r_ov || o_res.ready);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            S_DIFF: begin
                add_a   = W'(r_now);
                add_b   = W'(r_mark);
                add_sub = 1'b1;
            end
            S_ACCUM: begin
                add_a = r_enter ? W'(r_out_tot) : W'(r_in_tot);
                add_b = r_acc;
            end
            S_SUM: begin
                add_a = W'(r_in_tot);
                add_b = W'(r_out_tot);
            end
            S_MUL: begin
                add_a = r_acc;
                add_b = RATIO_SCALE[r_cnt] ? (W'(r_in_tot) << r_cnt) : '0;
            end
            S_DIV: begin
                add_a   = r_acc;
                add_b   = W'(r_dvs) << r_cnt;
                add_sub = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W+1)'(add_sub);
        sat_val = (|add_sum[W:TIME_BITS]) ? '1 : add_sum[TIME_BITS-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_OUT;
                    priority case (i_evt.operation)
                        OP_ENTER: begin
                            if (!(&r_depth) && r_depth == '0 && r_mark != '0) begin
                                n_state = S_DIFF;
                            end
                        end
                        OP_LEAVE: begin
                            if (r_depth == DEPTH_BITS'(1)) begin
                                n_state = S_DIFF;
                            end
                        end
                        OP_QUERY: begin
                            if ((r_in_tot | r_out_tot) != '0) begin
                                n_state = S_SUM;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DIFF:  n_state = S_ACCUM;
            S_ACCUM: n_state = S_OUT;
            S_SUM:   n_state = S_MUL;
            S_MUL:   n_state = (r_cnt == 4'(RATIO_BITS-1)) ? S_DIV : S_MUL;
            S_DIV:   n_state = (r_cnt == 4'd0) ? S_OUT : S_DIV;
            S_OUT:   n_state = load_out ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mark    <= '0;
            r_in_tot  <= '0;
            r_out_tot <= '0;
            r_depth   <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now      <= now;
                        r_interval <= '0;
                        r_ratio    <= '0;
                        r_err      <= 1'b0;
                        r_enter    <= (i_evt.operation == OP_ENTER);
                        unique case (i_evt.operation)
                            OP_ENTER: begin
                                if (&r_depth) begin
                                    r_err <= 1'b1;
                                end else begin
                                    r_depth <= r_depth + DEPTH_BITS'(1);
                                    if (r_depth == '0 && r_mark == '0) begin
                                        r_mark <= now;
                                    end
                                end
                            end
                            OP_LEAVE: begin
                                if (r_depth == '0) begin
                                    r_err <= 1'b1;
                                end else begin
                                    r_depth <= r_depth - DEPTH_BITS'(1);
                                end
                            end
                            OP_CLEAR: begin
                                r_mark    <= '0;
                                r_in_tot  <= '0;
                                r_out_tot <= '0;
                                r_depth   <= '0;
                            end
                            OP_QUERY: begin
                                r_acc <= '0;
                            end
                            default: r_acc <= '0;
                        endcase
                    end
                end
                S_DIFF: begin
                    r_acc      <= W'(add_sum[TIME_BITS-1:0]);
                    r_interval <= add_sum[INTERVAL_BITS-1:0];
                    r_mark     <= r_now;
                end
                S_ACCUM: begin
                    if (r_enter) begin
                        r_out_tot <= sat_val;
                    end else begin
                        r_in_tot <= sat_val;
                    end
                end
                S_SUM: begin
                    r_dvs <= add_sum[TIME_BITS:0];
                    r_acc <= '0;
                    r_cnt <= '0;
                end
                S_MUL: begin
                    r_acc <= add_sum[W-1:0];
                    if (r_cnt == 4'(RATIO_BITS-1)) begin
                        r_cnt <= 4'(RATIO_BITS-1);
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DIV: begin
                    if (add_sum[W]) begin
                        r_acc <= add_sum[W-1:0];
                    end
                    r_quo <= {r_quo[RATIO_BITS-2:0], add_sum[W]};
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_ratio <= {r_quo[RATIO_BITS-2:0], add_sum[W]};
                    end
                end
                S_OUT: begin
                    r_cnt <= '0;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_interval <= r_interval;
            r_o_ratio    <= r_ratio;
            r_o_err      <= r_err;
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.interval = r_o_interval;
    assign o_res.ratio    = r_o_ratio;
    assign o_res.error    = r_o_err;

endmodule
